### rtl/binary_delta_patch_apply_defines.svh
// Assertion macros shared by the patch applier RTL.
`ifndef BINARY_DELTA_PATCH_APPLY_DEFINES_SVH
`define BINARY_DELTA_PATCH_APPLY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bdpa_pkg.sv
// Types, constants and codes for the bsdiff patch applier.
`default_nettype none

package bdpa_pkg;

    localparam int unsigned OLD_DEPTH = 65536;
    localparam int OLD_AW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1;
    localparam int OLD_CW = $clog2(OLD_DEPTH + 1);
    localparam int OLD_LEN_W = 17;
    localparam int CMP_W = (OLD_CW > OLD_LEN_W) ? OLD_CW : OLD_LEN_W;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CTRL  = 2'd1;
    localparam logic [1:0] CMD_DIFF  = 2'd2;
    localparam logic [1:0] CMD_EXTRA = 2'd3;

    localparam logic [1:0] ST_BYTE       = 2'd0;
    localparam logic [1:0] ST_CTRL_OK    = 2'd1;
    localparam logic [1:0] ST_CTRL_BAD   = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    localparam logic [1:0] PH_CONTROL = 2'd0;
    localparam logic [1:0] PH_DIFF    = 2'd1;
    localparam logic [1:0] PH_EXTRA   = 2'd2;

    localparam logic CFG_NEW_LEN = 1'b0;
    localparam logic CFG_OLD_LEN = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [63:0] add_length_word;
        logic [63:0] extra_length_word;
        logic [63:0] seek_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  new_byte;
        logic [31:0] new_index;
        logic [1:0]  status;
        logic        finished;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/binary_delta_patch_apply.sv
// Top level of the bsdiff patch applier: old-file store, control tracking, output stage.
// An accepted input item passes through the stage-1 register and then the output register before its result is offered.
// Throughput: one item per cycle while the output is not stalled; the old-store read port is the one shared resource.
// Loads write the old store through its single write port.
// Reset clears all control state, sizes and the sticky error; the old store is not cleared.
`default_nettype none
`include "binary_delta_patch_apply_defines.svh"

module binary_delta_patch_apply import bdpa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [7:0] r_old_store [0:OLD_DEPTH-1];
    logic [7:0] r_rdata;

    logic [31:0]          r_new_len;
    logic [OLD_LEN_W-1:0] r_old_len;
    logic [OLD_CW-1:0]    r_load_ptr, n_load_ptr;
    logic [31:0]          r_new_pos, n_new_pos;
    logic [32:0]          r_room, n_room;
    logic [63:0]          r_old_pos, n_old_pos;
    logic [31:0]          r_add_rem, n_add_rem;
    logic [31:0]          r_extra_rem, n_extra_rem;
    logic [63:0]          r_seek, n_seek;
    logic [1:0]           r_phase, n_phase;
    logic                 r_err, n_err;

    logic      r_s1_valid, r_s1_use_old;
    t_out_item r_s1, n_s1;
    t_out_item s1_out;
    logic      n_s1_load, n_s1_use_old;
    logic      r_out_valid;
    t_out_item r_out;

    logic                  accept, s1_move;
    logic                  mem_we, mem_re;
    logic [CMP_W-1:0]      eff_old;
    logic                  load_ok, old_in_range, done_now, almost_done;
    logic [62:0]           add_m, extra_m;
    logic                  add_neg, extra_neg, triple_bad;
    logic [32:0]           len_sum;
    logic [63:0]           seek_mag;
    logic [63:0]           pos_b;
    logic                  pos_c;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign eff_old = (CMP_W'(r_old_len) > CMP_W'(OLD_DEPTH)) ? CMP_W'(OLD_DEPTH)
                                                             : CMP_W'(r_old_len);
    assign load_ok      = CMP_W'(r_load_ptr) < eff_old;
    assign old_in_range = (r_old_pos[63:CMP_W] == '0) && (r_old_pos[CMP_W-1:0] < eff_old);
    assign done_now     = r_room[32] || (r_room == '0);
    assign almost_done  = done_now || (r_room == 33'd1);

    assign add_m     = i_in_item.add_length_word[62:0];
    assign extra_m   = i_in_item.extra_length_word[62:0];
    assign add_neg   = i_in_item.add_length_word[63] && (add_m != '0);
    assign extra_neg = i_in_item.extra_length_word[63] && (extra_m != '0);
    assign len_sum   = {1'b0, add_m[31:0]} + {1'b0, extra_m[31:0]};
    assign triple_bad = add_neg || extra_neg
                     || (add_m[62:32] != '0) || (extra_m[62:32] != '0)
                     || (len_sum > {1'b0, r_room[31:0]});
    assign seek_mag  = {1'b0, i_in_item.seek_word[62:0]};

    assign n_old_pos = r_old_pos + pos_b + {63'd0, pos_c};

    always_comb begin
        n_load_ptr   = r_load_ptr;
        n_new_pos    = r_new_pos;
        n_room       = r_room;
        n_add_rem    = r_add_rem;
        n_extra_rem  = r_extra_rem;
        n_seek       = r_seek;
        n_phase      = r_phase;
        n_err        = r_err;
        pos_b        = '0;
        pos_c        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        n_s1_load    = 1'b0;
        n_s1_use_old = 1'b0;
        n_s1.new_byte  = 8'd0;
        n_s1.new_index = r_new_pos;
        n_s1.status    = ST_UNEXPECTED;
        n_s1.finished  = done_now;

        if (accept) begin
            if (r_err) begin
                n_s1_load = 1'b1;
            end else begin
                unique case (i_in_item.cmd)
                    CMD_LOAD: begin
                        if (r_phase != PH_CONTROL || !load_ok) begin
                            n_s1_load = 1'b1;
                            n_err     = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            n_load_ptr = r_load_ptr + 1'b1;
                        end
                    end
                    CMD_CTRL: begin
                        n_s1_load = 1'b1;
                        if (r_phase != PH_CONTROL || done_now) begin
                            n_err = 1'b1;
                        end else if (triple_bad) begin
                            n_err       = 1'b1;
                            n_s1.status = ST_CTRL_BAD;
                        end else begin
                            n_s1.status = ST_CTRL_OK;
                            n_add_rem   = add_m[31:0];
                            n_extra_rem = extra_m[31:0];
                            n_seek      = i_in_item.seek_word[63] ? (64'd0 - seek_mag)
                                                                  : seek_mag;
                            if (add_m[31:0] != '0) begin
                                n_phase = PH_DIFF;
                            end else if (extra_m[31:0] != '0) begin
                                n_phase = PH_EXTRA;
                            end else begin
                                pos_b   = i_in_item.seek_word[63] ? ~seek_mag : seek_mag;
                                pos_c   = i_in_item.seek_word[63];
                                n_seek  = '0;
                            end
                        end
                    end
                    CMD_DIFF: begin
                        n_s1_load = 1'b1;
                        if (r_phase != PH_DIFF) begin
                            n_err = 1'b1;
                        end else begin
                            mem_re         = old_in_range;
                            n_s1_use_old   = old_in_range;
                            n_s1.new_byte  = i_in_item.data_byte;
                            n_s1.status    = ST_BYTE;
                            n_s1.finished  = almost_done;
                            n_new_pos      = r_new_pos + 32'd1;
                            n_room         = r_room - 33'd1;
                            n_add_rem      = r_add_rem - 32'd1;
                            pos_c          = 1'b1;
                            if (r_add_rem == 32'd1) begin
                                if (r_extra_rem != '0) begin
                                    n_phase = PH_EXTRA;
                                end else begin
                                    pos_b   = r_seek;
                                    n_seek  = '0;
                                    n_phase = PH_CONTROL;
                                end
                            end
                        end
                    end
                    CMD_EXTRA: begin
                        n_s1_load = 1'b1;
                        if (r_phase != PH_EXTRA) begin
                            n_err = 1'b1;
                        end else begin
                            n_s1.new_byte = i_in_item.data_byte;
                            n_s1.status   = ST_BYTE;
                            n_s1.finished = almost_done;
                            n_new_pos     = r_new_pos + 32'd1;
                            n_room        = r_room - 33'd1;
                            n_extra_rem   = r_extra_rem - 32'd1;
                            if (r_extra_rem == 32'd1) begin
                                pos_b   = r_seek;
                                n_seek  = '0;
                                n_phase = PH_CONTROL;
                            end
                        end
                    end
                    default: begin
                        n_s1_load = 1'b1;
                        n_err     = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_old_store[r_load_ptr[OLD_AW-1:0]] <= i_in_item.data_byte;
        end
        if (mem_re) begin
            r_rdata <= r_old_store[r_old_pos[OLD_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_len   <= '0;
            r_old_len   <= '0;
            r_load_ptr  <= '0;
            r_new_pos   <= '0;
            r_room      <= '0;
            r_old_pos   <= '0;
            r_add_rem   <= '0;
            r_extra_rem <= '0;
            r_seek      <= '0;
            r_phase     <= PH_CONTROL;
            r_err       <= 1'b0;
        end else begin
            r_load_ptr  <= n_load_ptr;
            r_new_pos   <= n_new_pos;
            r_old_pos   <= n_old_pos;
            r_add_rem   <= n_add_rem;
            r_extra_rem <= n_extra_rem;
            r_seek      <= n_seek;
            r_phase     <= n_phase;
            r_err       <= n_err;
            if (i_cfg_we && (i_cfg_index == CFG_NEW_LEN)) begin
                r_new_len <= i_cfg_data;
                r_room    <= {1'b0, i_cfg_data} - {1'b0, r_new_pos};
            end else begin
                r_room <= n_room;
            end
            if (i_cfg_we && (i_cfg_index == CFG_OLD_LEN)) begin
                r_old_len <= i_cfg_data[OLD_LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= n_s1_load;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        s1_out          = r_s1;
        s1_out.new_byte = r_s1.new_byte + (r_s1_use_old ? r_rdata : 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_s1_load) begin
            r_s1         <= n_s1;
            r_s1_use_old <= n_s1_use_old;
        end
        if (s1_move) begin
            r_out <= s1_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `BDPA_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err, r_err, "sticky error cleared")
    `BDPA_ASSERT_NOW(a_room_track, i_clk, i_rst_n, 1'b1,
        r_room == ({1'b0, r_new_len} - {1'b0, r_new_pos}), "room out of step")
    `BDPA_ASSERT_NOW(a_diff_count, i_clk, i_rst_n, r_phase == PH_DIFF,
        r_add_rem != '0, "diff phase with no bytes left")
    `BDPA_ASSERT_NOW(a_extra_count, i_clk, i_rst_n, r_phase == PH_EXTRA,
        (r_extra_rem != '0) && (r_add_rem == '0), "extra phase count mismatch")
    `BDPA_ASSERT_NOW(a_old_use, i_clk, i_rst_n, r_s1_valid && r_s1_use_old,
        r_s1.status == ST_BYTE, "old byte added to a non-byte item")

endmodule

`default_nettype wire
